/* design/i2c_master_transaction_sequencer_assert.svh */
// Assertion macros for the I2C master transaction sequencer checker.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef I2C_MASTER_TRANSACTION_SEQUENCER_ASSERT_SVH
`define I2C_MASTER_TRANSACTION_SEQUENCER_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define SEQ_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sequencer assertion failed");

// Next-cycle implication, disabled while reset is held.
`define SEQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sequencer assertion failed");

`endif

/* design/i2cseq_pkg.sv */
// Shared types and constants for the I2C master transaction sequencer.
// No dependencies; used by the control module and the top level.
`default_nettype none

package i2cseq_pkg;

  // Receive buffer depth and the derived receive limit.
  localparam int BUFFER_DEPTH = 32;
  localparam int RX_LIMIT     = (BUFFER_DEPTH < 32) ? BUFFER_DEPTH : 32;

  // Transmit store geometry.
  localparam int TX_SLOTS = 32;
  localparam int TX_AW    = $clog2(TX_SLOTS);

  localparam logic [5:0] IDX_MAX = 6'd63;

  // Request kinds.
  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_EVENT = 2'd2;

  // Configuration register indices.
  localparam logic [1:0] CFG_DEV_ADDR = 2'd0;
  localparam logic [1:0] CFG_WR_COUNT = 2'd1;
  localparam logic [1:0] CFG_RD_COUNT = 2'd2;

  // Acknowledge control codes.
  localparam logic [1:0] ACK_KEEP     = 2'd0;
  localparam logic [1:0] ACK_ASSERT   = 2'd1;
  localparam logic [1:0] ACK_WITHDRAW = 2'd2;

  // Bus engine status codes.
  localparam logic [7:0] ST_START        = 8'h08;
  localparam logic [7:0] ST_RESTART      = 8'h10;
  localparam logic [7:0] ST_SLAW_ACK     = 8'h18;
  localparam logic [7:0] ST_SLAW_NACK    = 8'h20;
  localparam logic [7:0] ST_TXDATA_ACK   = 8'h28;
  localparam logic [7:0] ST_TXDATA_NACK  = 8'h30;
  localparam logic [7:0] ST_ARB_LOST     = 8'h38;
  localparam logic [7:0] ST_SLAR_ACK     = 8'h40;
  localparam logic [7:0] ST_SLAR_NACK    = 8'h48;
  localparam logic [7:0] ST_RXDATA_ACK   = 8'h50;
  localparam logic [7:0] ST_RXDATA_NACK  = 8'h58;

  typedef enum logic [3:0] {
    PH_IDLE        = 4'd0,
    PH_START       = 4'd1,
    PH_RESTART     = 4'd2,
    PH_SLAVE_ACK   = 4'd3,
    PH_SLAVE_NACK  = 4'd4,
    PH_REP_START   = 4'd5,
    PH_MASTER_ACK  = 4'd6,
    PH_MASTER_NACK = 4'd7,
    PH_ERROR       = 4'd8
  } phase_t;

  typedef struct packed {
    logic [5:0] wr_idx;
    logic [5:0] rd_idx;
    phase_t     phase;
    logic       busy;
  } seq_state_t;

  typedef struct packed {
    logic [6:0] dev_addr;
    logic [5:0] wr_count;
    logic [5:0] rd_count;
  } seq_cfg_t;

  // One result; tx_fetch selects the store read data for tx_byte.
  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       tx_fetch;
    logic       tx_beyond;
    logic       set_start;
    logic       clear_start;
    logic       set_stop;
    logic [1:0] ack_control;
    logic       rx_valid;
    logic [4:0] rx_index;
    logic [7:0] rx_byte;
    logic       overflow;
    logic       done_res;
    logic [3:0] final_status;
  } seq_result_t;

endpackage

`default_nettype wire

/* design/i2c_master_transaction_sequencer.sv */
// Top level of the I2C master transaction sequencer: transmit store, state, result register.
// Depends on i2cseq_pkg and i2cseq_ctrl.
`default_nettype none

// The sequencer drives the master side of an I2C write, read or
// write-restart-read transaction. Software loads transmit bytes with load
// requests, then issues a start request; after that every bus status event
// from the engine is answered with one result carrying the byte for the data
// register, start/stop/acknowledge controls, any received byte with its
// position, and a done flag with the final phase. Every request, including
// loads and ignored starts, produces exactly one result. One request is
// accepted per clock cycle while the output register is empty or being
// drained; its result and the transmit store read, made at the current
// write index, are both registered when the request is accepted. The
// output register lets a new request enter in the same cycle the previous
// result is taken, so with out_ready held high the block runs at one request
// per cycle. The transmit store is not cleared by reset; sending a byte from
// an entry that was never loaded gives an unspecified value. Configuration
// writes are always accepted and take effect for the next request.

module i2c_master_transaction_sequencer (
  input  logic       clk,
  input  logic       rst_n,

  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_action,
  input  logic [4:0] in_load_index,
  input  logic [7:0] in_load_byte,
  input  logic [7:0] in_status_code,
  input  logic [7:0] in_rx_data,

  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_tx_valid,
  output logic [7:0] out_tx_byte,
  output logic       out_set_start,
  output logic       out_clear_start,
  output logic       out_set_stop,
  output logic [1:0] out_ack_control,
  output logic       out_rx_valid,
  output logic [4:0] out_rx_index,
  output logic [7:0] out_rx_byte,
  output logic       out_overflow,
  output logic       out_done_res,
  output logic [3:0] out_final_status,

  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [6:0] cfg_data
);
  import i2cseq_pkg::*;

  seq_state_t  state_r;
  seq_state_t  state_nxt;
  seq_cfg_t    cfg_r;
  seq_result_t res_nxt;
  seq_result_t res_r;
  logic        out_valid_r;
  logic        in_acc;
  logic        load_en;

  // Transmit store: one write port for loads, one registered read port.
  logic [7:0]       tx_mem [TX_SLOTS];
  logic [7:0]       mem_q_r;
  logic [TX_AW-1:0] rd_addr;

  // A request is taken whenever the output register is empty or being drained.
  assign in_ready  = !out_valid_r || out_ready;
  assign in_acc    = in_valid && in_ready;
  assign load_en   = in_acc && (in_action == ACT_LOAD);
  assign cfg_ready = 1'b1;

  // The store is read at the write index every accepted request; only fetching
  // events use the data. A load never shares an edge with another request, so
  // no forwarding between the write and read ports is needed.
  assign rd_addr = state_r.wr_idx[TX_AW-1:0];

  always_ff @(posedge clk) begin
    if (load_en) begin
      tx_mem[in_load_index] <= in_load_byte;
    end
    if (in_acc) begin
      mem_q_r <= tx_mem[rd_addr];
    end
  end

  i2cseq_ctrl u_ctrl (
    .action      (in_action),
    .status_code (in_status_code),
    .rx_data     (in_rx_data),
    .st          (state_r),
    .cfg         (cfg_r),
    .st_nxt      (state_nxt),
    .res         (res_nxt)
  );

  // Sequencer state, including the phase register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '{wr_idx: 6'd0, rd_idx: 6'd0, phase: PH_IDLE, busy: 1'b0};
    end else if (in_acc) begin
      state_r <= state_nxt;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_DEV_ADDR: cfg_r.dev_addr <= cfg_data;
        CFG_WR_COUNT: cfg_r.wr_count <= cfg_data[5:0];
        CFG_RD_COUNT: cfg_r.rd_count <= cfg_data[5:0];
        default: begin
        end
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_tx_valid     = res_r.tx_valid;
  // A fetched byte comes from the store; an index beyond the store sends zero.
  assign out_tx_byte      = res_r.tx_fetch ? (res_r.tx_beyond ? 8'd0 : mem_q_r)
                                           : res_r.tx_byte;
  assign out_set_start    = res_r.set_start;
  assign out_clear_start  = res_r.clear_start;
  assign out_set_stop     = res_r.set_stop;
  assign out_ack_control  = res_r.ack_control;
  assign out_rx_valid     = res_r.rx_valid;
  assign out_rx_index     = res_r.rx_index;
  assign out_rx_byte      = res_r.rx_byte;
  assign out_overflow     = res_r.overflow;
  assign out_done_res     = res_r.done_res;
  assign out_final_status = res_r.final_status;

endmodule

`default_nettype wire

/* design/i2cseq_ctrl.sv */
// Decision logic of the I2C master transaction sequencer: next state and result.
// Depends on i2cseq_pkg.
`default_nettype none

module i2cseq_ctrl (
  input  logic [1:0]              action,
  input  logic [7:0]              status_code,
  input  logic [7:0]              rx_data,
  input  i2cseq_pkg::seq_state_t  st,
  input  i2cseq_pkg::seq_cfg_t    cfg,
  output i2cseq_pkg::seq_state_t  st_nxt,
  output i2cseq_pkg::seq_result_t res
);
  import i2cseq_pkg::*;

  logic [7:0] addr_w;
  logic [5:0] wi_bump;
  logic [5:0] ri_bump;
  logic       recv;

  assign addr_w  = {cfg.dev_addr, 1'b0};
  assign wi_bump = (st.wr_idx < IDX_MAX) ? st.wr_idx + 6'd1 : IDX_MAX;
  assign ri_bump = (st.rd_idx < IDX_MAX) ? st.rd_idx + 6'd1 : IDX_MAX;

  always_comb begin
    st_nxt = st;
    res    = '0;
    recv   = 1'b0;
    unique case (action)
      ACT_LOAD: begin
      end
      ACT_START: begin
        if (!st.busy) begin
          st_nxt.busy   = 1'b1;
          res.set_start = 1'b1;
        end
      end
      ACT_EVENT: begin
        unique case (status_code)
          ST_START: begin
            st_nxt.phase    = PH_START;
            res.tx_valid    = 1'b1;
            res.clear_start = 1'b1;
            if (cfg.wr_count != 6'd0) begin
              st_nxt.wr_idx = 6'd0;
              res.tx_byte   = addr_w;
            end else begin
              st_nxt.rd_idx = 6'd0;
              res.tx_byte   = addr_w | 8'd1;
            end
          end
          ST_RESTART: begin
            st_nxt.phase    = PH_RESTART;
            st_nxt.rd_idx   = 6'd0;
            res.tx_valid    = 1'b1;
            res.tx_byte     = addr_w | 8'd1;
            res.clear_start = 1'b1;
          end
          ST_SLAW_ACK: begin
            res.tx_valid  = 1'b1;
            res.tx_fetch  = 1'b1;
            res.tx_beyond = (st.wr_idx >= 6'(TX_SLOTS));
            st_nxt.wr_idx = wi_bump;
            st_nxt.phase  = PH_SLAVE_ACK;
          end
          ST_SLAW_NACK, ST_TXDATA_NACK, ST_SLAR_NACK: begin
            st_nxt.phase = PH_SLAVE_NACK;
            res.set_stop = 1'b1;
            res.done_res = 1'b1;
          end
          ST_TXDATA_ACK: begin
            if (st.wr_idx < cfg.wr_count) begin
              res.tx_valid  = 1'b1;
              res.tx_fetch  = 1'b1;
              res.tx_beyond = (st.wr_idx >= 6'(TX_SLOTS));
              st_nxt.wr_idx = wi_bump;
              st_nxt.phase  = PH_SLAVE_ACK;
            end else if (cfg.rd_count != 6'd0) begin
              st_nxt.phase  = PH_REP_START;
              res.set_start = 1'b1;
            end else begin
              st_nxt.phase = PH_SLAVE_ACK;
              res.set_stop = 1'b1;
              res.done_res = 1'b1;
            end
          end
          ST_ARB_LOST: begin
            st_nxt.phase  = PH_START;
            st_nxt.wr_idx = 6'd0;
            st_nxt.rd_idx = 6'd0;
            res.set_start = 1'b1;
          end
          ST_SLAR_ACK: begin
            res.ack_control = (cfg.rd_count <= 6'd1) ? ACK_WITHDRAW : ACK_ASSERT;
          end
          ST_RXDATA_ACK: begin
            recv = 1'b1;
          end
          ST_RXDATA_NACK: begin
            recv         = 1'b1;
            st_nxt.phase = PH_MASTER_NACK;
            res.set_stop = 1'b1;
            res.done_res = 1'b1;
          end
          default: begin
            // Any unknown status is handled as a bus error.
            st_nxt.wr_idx = 6'd0;
            st_nxt.rd_idx = 6'd0;
            st_nxt.phase  = PH_ERROR;
            res.set_stop  = 1'b1;
            res.done_res  = 1'b1;
          end
        endcase

        if (recv) begin
          if ({1'b0, st.rd_idx} < 7'(RX_LIMIT)) begin
            res.rx_valid = 1'b1;
            res.rx_index = st.rd_idx[4:0];
            res.rx_byte  = rx_data;
          end else begin
            res.overflow = 1'b1;
          end
          st_nxt.rd_idx = ri_bump;
          if (status_code == ST_RXDATA_ACK) begin
            if (({1'b0, ri_bump} + 7'd1) < {1'b0, cfg.rd_count}) begin
              st_nxt.phase    = PH_MASTER_ACK;
              res.ack_control = ACK_ASSERT;
            end else begin
              st_nxt.phase    = PH_MASTER_NACK;
              res.ack_control = ACK_WITHDRAW;
            end
          end
        end

        if (res.done_res) begin
          res.final_status = st_nxt.phase;
          st_nxt.wr_idx    = 6'd0;
          st_nxt.rd_idx    = 6'd0;
          st_nxt.phase     = PH_IDLE;
          st_nxt.busy      = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

/* design/i2cseq_chk.sv */
// Port-level checker for the I2C master transaction sequencer, bound to the top level.
// Depends on i2c_master_transaction_sequencer_assert.svh.
`default_nettype none

module i2cseq_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_tx_byte,
  input logic       out_set_stop,
  input logic       out_rx_valid,
  input logic       out_overflow,
  input logic       out_done_res,
  input logic [3:0] out_final_status
);
`include "i2c_master_transaction_sequencer_assert.svh"

  // Every accepted request leaves a result in the next cycle.
  `SEQ_ASSERT_NEXT(a_req_gives_result, in_valid && in_ready, out_valid)

  // A waiting result keeps its transmit byte.
  `SEQ_ASSERT_NEXT(a_tx_hold, out_valid && !out_ready, out_valid && $stable(out_tx_byte))

  // Every finished transaction ends with a stop request.
  `SEQ_ASSERT_IMPL(a_done_stops, out_valid && out_done_res, out_set_stop)

  // A received byte is either stored or dropped, never both.
  `SEQ_ASSERT_IMPL(a_rx_excl, out_valid, !(out_rx_valid && out_overflow))

  // The final status is only reported with done.
  `SEQ_ASSERT_IMPL(a_fin_zero, out_valid && !out_done_res, out_final_status == 4'd0)

endmodule

bind i2c_master_transaction_sequencer i2cseq_chk u_i2cseq_chk (.*);

`default_nettype wire

/* verif/testbench.sv */
`timescale 1ns / 100ps
// Self-checking bench for the I2C master transaction sequencer.
// Needs i2cseq_pkg and the sequencer RTL with i2cseq_ctrl; no other files.

module testbench;
  import i2cseq_pkg::*;

  localparam int HALF_PERIOD = 5;
  localparam int CYCLE_LIMIT = 300000;
  localparam int PRINT_LIMIT = 30;

  // The fourth request kind has no meaning; the block answers it with all zeros.
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  // Status codes outside the handled set. Both must end the transfer as a bus error.
  localparam logic [7:0] ST_BUS_ERROR = 8'h00;
  localparam logic [7:0] ST_UNDEFINED = 8'hFF;

  // One answer of the sequencer, laid out field by field as on the ports.
  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       set_start;
    logic       clear_start;
    logic       set_stop;
    logic [1:0] ack_control;
    logic       rx_valid;
    logic [4:0] rx_index;
    logic [7:0] rx_byte;
    logic       overflow;
    logic       done_res;
    logic [3:0] final_status;
  } bus_answer_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;

  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] in_action = '0;
  logic [4:0] in_load_index = '0;
  logic [7:0] in_load_byte = '0;
  logic [7:0] in_status_code = '0;
  logic [7:0] in_rx_data = '0;

  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       out_tx_valid;
  logic [7:0] out_tx_byte;
  logic       out_set_start;
  logic       out_clear_start;
  logic       out_set_stop;
  logic [1:0] out_ack_control;
  logic       out_rx_valid;
  logic [4:0] out_rx_index;
  logic [7:0] out_rx_byte;
  logic       out_overflow;
  logic       out_done_res;
  logic [3:0] out_final_status;

  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [6:0] cfg_data = '0;

  // Shadow copy of the sequencer: transmit store, indices, phase, busy flag and
  // the three configuration registers; the state advances once per accepted request.
  logic [7:0] shadow_store [0:TX_SLOTS-1];
  logic [5:0] shadow_wr_idx = '0;
  logic [5:0] shadow_rd_idx = '0;
  phase_t     shadow_phase = PH_IDLE;
  logic       shadow_busy = 1'b0;
  logic [6:0] shadow_addr = '0;
  logic [5:0] shadow_wr_count = '0;
  logic [5:0] shadow_rd_count = '0;

  // Answers predicted for accepted requests, oldest first.
  bus_answer_t pending_answers [$];
  bus_answer_t seen_answer;
  bus_answer_t want_answer;

  int mismatch_count = 0;
  int bus_requests = 0;
  int cycle_count = 0;
  // Longest idle stretch either side may draw per request; zero gives full-rate bursts.
  int gap_max = 5;
  int sink_wait = 0;

  i2c_master_transaction_sequencer dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_load_index    (in_load_index),
    .in_load_byte     (in_load_byte),
    .in_status_code   (in_status_code),
    .in_rx_data       (in_rx_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_tx_valid     (out_tx_valid),
    .out_tx_byte      (out_tx_byte),
    .out_set_start    (out_set_start),
    .out_clear_start  (out_clear_start),
    .out_set_stop     (out_set_stop),
    .out_ack_control  (out_ack_control),
    .out_rx_valid     (out_rx_valid),
    .out_rx_index     (out_rx_index),
    .out_rx_byte      (out_rx_byte),
    .out_overflow     (out_overflow),
    .out_done_res     (out_done_res),
    .out_final_status (out_final_status),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  // Indices count up and stick at their top value instead of wrapping.
  function automatic logic [5:0] step_index(input logic [5:0] v);
    return (v < IDX_MAX) ? v + 6'd1 : IDX_MAX;
  endfunction

  // Next transmit byte at the write index. Positions past the store send zero.
  function automatic logic [7:0] fetch_tx_byte();
    logic [7:0] b;
    b = (shadow_wr_idx < TX_SLOTS) ? shadow_store[shadow_wr_idx[4:0]] : 8'h00;
    shadow_wr_idx = step_index(shadow_wr_idx);
    return b;
  endfunction

  // Applies one request to the shadow sequencer and returns the answer it owes.
  function automatic bus_answer_t advance_sequencer(input logic [1:0] act,
                                                    input logic [4:0] lidx,
                                                    input logic [7:0] lbyte,
                                                    input logic [7:0] status,
                                                    input logic [7:0] rxd);
    bus_answer_t r;
    logic        got_byte;
    r = '0;
    got_byte = 1'b0;
    case (act)
      ACT_LOAD: begin
        shadow_store[lidx] = lbyte;
      end
      ACT_START: begin
        if (!shadow_busy) begin
          shadow_busy = 1'b1;
          r.set_start = 1'b1;
        end
      end
      ACT_EVENT: begin
        case (status)
          ST_START: begin
            shadow_phase = PH_START;
            r.tx_valid = 1'b1;
            r.clear_start = 1'b1;
            // With nothing to write, the first address already carries the read bit.
            if (shadow_wr_count != 0) begin
              shadow_wr_idx = '0;
              r.tx_byte = {shadow_addr, 1'b0};
            end else begin
              shadow_rd_idx = '0;
              r.tx_byte = {shadow_addr, 1'b1};
            end
          end
          ST_RESTART: begin
            shadow_phase = PH_RESTART;
            shadow_rd_idx = '0;
            r.tx_valid = 1'b1;
            r.tx_byte = {shadow_addr, 1'b1};
            r.clear_start = 1'b1;
          end
          ST_SLAW_ACK: begin
            r.tx_valid = 1'b1;
            r.tx_byte = fetch_tx_byte();
            shadow_phase = PH_SLAVE_ACK;
          end
          ST_SLAW_NACK, ST_TXDATA_NACK, ST_SLAR_NACK: begin
            shadow_phase = PH_SLAVE_NACK;
            r.set_stop = 1'b1;
            r.done_res = 1'b1;
          end
          ST_TXDATA_ACK: begin
            if (shadow_wr_idx < shadow_wr_count) begin
              r.tx_valid = 1'b1;
              r.tx_byte = fetch_tx_byte();
              shadow_phase = PH_SLAVE_ACK;
            end else if (shadow_rd_count != 0) begin
              shadow_phase = PH_REP_START;
              r.set_start = 1'b1;
            end else begin
              shadow_phase = PH_SLAVE_ACK;
              r.set_stop = 1'b1;
              r.done_res = 1'b1;
            end
          end
          ST_ARB_LOST: begin
            shadow_phase = PH_START;
            shadow_wr_idx = '0;
            shadow_rd_idx = '0;
            r.set_start = 1'b1;
          end
          ST_SLAR_ACK: begin
            r.ack_control = (shadow_rd_count <= 1) ? ACK_WITHDRAW : ACK_ASSERT;
          end
          ST_RXDATA_ACK: begin
            got_byte = 1'b1;
          end
          ST_RXDATA_NACK: begin
            got_byte = 1'b1;
            shadow_phase = PH_MASTER_NACK;
            r.set_stop = 1'b1;
            r.done_res = 1'b1;
          end
          default: begin
            shadow_wr_idx = '0;
            shadow_rd_idx = '0;
            shadow_phase = PH_ERROR;
            r.set_stop = 1'b1;
            r.done_res = 1'b1;
          end
        endcase
        if (got_byte) begin
          // Bytes past the receive buffer are dropped, but the index still moves.
          if (shadow_rd_idx < RX_LIMIT) begin
            r.rx_valid = 1'b1;
            r.rx_index = shadow_rd_idx[4:0];
            r.rx_byte = rxd;
          end else begin
            r.overflow = 1'b1;
          end
          shadow_rd_idx = step_index(shadow_rd_idx);
          if (status == ST_RXDATA_ACK) begin
            if (({1'b0, shadow_rd_idx} + 7'd1) < {1'b0, shadow_rd_count}) begin
              shadow_phase = PH_MASTER_ACK;
              r.ack_control = ACK_ASSERT;
            end else begin
              shadow_phase = PH_MASTER_NACK;
              r.ack_control = ACK_WITHDRAW;
            end
          end
        end
        if (r.done_res) begin
          r.final_status = shadow_phase;
          shadow_wr_idx = '0;
          shadow_rd_idx = '0;
          shadow_phase = PH_IDLE;
          shadow_busy = 1'b0;
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT)
      $display("%0t: %s is 0x%0h, should be 0x%0h", $time, field, got, want);
  endtask

  // Hands one request to the block after a random pause and predicts its answer
  // at the edge that accepts it. Returns right after that edge.
  task automatic send_request(input logic [1:0] act, input logic [4:0] lidx,
                              input logic [7:0] lbyte, input logic [7:0] status,
                              input logic [7:0] rxd);
    int gap;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_load_index <= lidx;
    in_load_byte <= lbyte;
    in_status_code <= status;
    in_rx_data <= rxd;
    do @(posedge clk); while (!in_ready);
    pending_answers.push_back(advance_sequencer(act, lidx, lbyte, status, rxd));
    if (act != ACT_UNUSED && act != ACT_START) bus_requests++;
  endtask

  // A bus event with a random received byte; the load fields are don't-care noise.
  task automatic send_event(input logic [7:0] status);
    send_request(ACT_EVENT, $urandom, $urandom, status, $urandom);
  endtask

  task automatic send_start();
    send_request(ACT_START, $urandom, $urandom, $urandom, $urandom);
  endtask

  // Lowers valid and waits for every outstanding answer, plus the output
  // register's latency, so that the block is quiet before a register write.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Leaves cfg_valid high; the caller lowers it after the last register.
  task automatic write_register(input logic [1:0] idx, input logic [6:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_DEV_ADDR: shadow_addr = value;
      CFG_WR_COUNT: shadow_wr_count = value[5:0];
      CFG_RD_COUNT: shadow_rd_count = value[5:0];
      default: begin
      end
    endcase
  endtask

  task automatic program_sequencer(input logic [6:0] addr, input int n_wr, input int n_rd);
    wait_idle();
    write_register(CFG_DEV_ADDR, addr);
    write_register(CFG_WR_COUNT, 7'(n_wr));
    write_register(CFG_RD_COUNT, 7'(n_rd));
    cfg_valid <= 1'b0;
  endtask

  // Mostly short transfers so many fit in the run; now and then up to 32 bytes long.
  function automatic int short_len(input int lo);
    return ($urandom_range(0, 7) == 0) ? $urandom_range(lo, 32) : $urandom_range(lo, 6);
  endfunction

  // A random status code the sequencer does not handle. Handled codes fold
  // onto the plain bus-error code so the result stays unknown.
  function automatic logic [7:0] random_unknown_code();
    logic [7:0] c;
    c = $urandom;
    case (c)
      ST_START, ST_RESTART, ST_SLAW_ACK, ST_SLAW_NACK, ST_TXDATA_ACK, ST_TXDATA_NACK,
      ST_ARB_LOST, ST_SLAR_ACK, ST_SLAR_NACK, ST_RXDATA_ACK, ST_RXDATA_NACK:
        c = ST_BUS_ERROR;
      default: begin
      end
    endcase
    return c;
  endfunction

  // Either a full-rate burst or random idling on both sides for the next test.
  task automatic pick_pace();
    gap_max = ($urandom_range(0, 3) == 0) ? 0 : 5;
  endtask

  // A well-formed transfer as the bus engine would report it: start, address,
  // the data bytes, then a repeated start and the reads if any. Loads may
  // slip in between bytes, as software may refill the store mid-transfer.
  task automatic run_transaction(input int n_wr, input int n_rd);
    int i;
    program_sequencer($urandom_range(0, 127), n_wr, n_rd);
    send_start();
    send_event(ST_START);
    if (n_wr > 0) begin
      send_event(ST_SLAW_ACK);
      for (i = 0; i < n_wr; i++) begin
        if ($urandom_range(0, 7) == 0)
          send_request(ACT_LOAD, $urandom, $urandom, $urandom, $urandom);
        send_event(ST_TXDATA_ACK);
      end
      if (n_rd > 0) send_event(ST_RESTART);
    end
    if (n_rd > 0) begin
      send_event(ST_SLAR_ACK);
      for (i = 1; i < n_rd; i++) send_event(ST_RXDATA_ACK);
      send_event(ST_RXDATA_NACK);
    end
  endtask

  // Every store entry gets written before anything can be sent from it.
  task automatic load_tx_store();
    int i;
    for (i = 0; i < TX_SLOTS; i++)
      send_request(ACT_LOAD, 5'(i), $urandom, $urandom, $urandom);
  endtask

  task automatic test_directed();
    gap_max = 5;
    program_sequencer(7'h7F, 1, 1);
    // The unused request kind with every other field at its top value.
    send_request(ACT_UNUSED, 5'd31, 8'hFF, 8'hFF, 8'hFF);
    send_start();
    // A second start while busy must be ignored.
    send_start();
    send_event(ST_START);
    send_event(ST_SLAW_ACK);
    // Loading while busy lands in the store at once.
    send_request(ACT_LOAD, 5'd31, 8'h00, 8'h00, 8'h00);
    send_event(ST_TXDATA_ACK);
    send_event(ST_RESTART);
    send_event(ST_SLAR_ACK);
    send_request(ACT_EVENT, 5'd0, 8'h00, ST_RXDATA_NACK, 8'hFF);
    // Events while idle are processed like any other.
    send_event(ST_BUS_ERROR);
    send_event(ST_UNDEFINED);
    send_request(ACT_EVENT, 5'd31, 8'hFF, ST_RXDATA_ACK, 8'h00);
    send_event(ST_ARB_LOST);
    send_event(ST_SLAW_NACK);
    send_event(ST_TXDATA_NACK);
    send_event(ST_SLAR_NACK);
    program_sequencer(7'h00, 0, 32);
    send_start();
    send_event(ST_START);
    send_event(ST_SLAR_ACK);
    send_request(ACT_EVENT, 5'd0, 8'hFF, ST_RXDATA_ACK, 8'h5A);
    send_event(ST_RXDATA_NACK);
  endtask

  task automatic test_write_only();
    pick_pace();
    run_transaction(short_len(1), 0);
  endtask

  task automatic test_read_only();
    pick_pace();
    run_transaction(0, short_len(1));
  endtask

  task automatic test_write_restart_read();
    pick_pace();
    run_transaction(short_len(1), short_len(1));
  endtask

  // A transfer cut short by a NACK, lost arbitration or an unknown status code.
  task automatic test_bus_faults();
    int n_wr;
    pick_pace();
    n_wr = short_len(1);
    program_sequencer($urandom_range(0, 127), n_wr, short_len(0));
    send_start();
    send_event(ST_START);
    case ($urandom_range(0, 4))
      0: send_event(ST_SLAW_NACK);
      1: begin
        send_event(ST_SLAW_ACK);
        repeat ($urandom_range(0, n_wr - 1)) send_event(ST_TXDATA_ACK);
        send_event(ST_TXDATA_NACK);
      end
      2: begin
        // Lost arbitration restarts from scratch with the transfer still open.
        send_event(ST_ARB_LOST);
        send_event(ST_START);
        send_event(ST_SLAW_ACK);
        send_event(ST_TXDATA_NACK);
      end
      3: send_event(ST_SLAR_NACK);
      default: send_event(random_unknown_code());
    endcase
  endtask

  // More bytes arrive than the receive buffer holds; the extra ones are dropped.
  task automatic test_receive_overflow();
    pick_pace();
    program_sequencer($urandom_range(0, 127), 0, 32);
    send_start();
    send_event(ST_START);
    send_event(ST_SLAR_ACK);
    repeat (35) send_event(ST_RXDATA_ACK);
    send_event(ST_RXDATA_NACK);
  endtask

  // Drives both indices to their ceiling: the write index runs past the store
  // and sends zeros, the read index runs far past the buffer.
  task automatic test_index_saturation();
    pick_pace();
    program_sequencer($urandom_range(0, 127), 32, 2);
    send_start();
    send_event(ST_START);
    repeat (66) send_event(ST_SLAW_ACK);
    send_event(ST_TXDATA_ACK);
    send_event(ST_RESTART);
    send_event(ST_SLAR_ACK);
    repeat (66) send_event(ST_RXDATA_ACK);
    send_event(ST_RXDATA_NACK);
  endtask

  // Unordered mix of every request kind and status code.
  task automatic test_noise();
    pick_pace();
    program_sequencer($urandom_range(0, 127), $urandom_range(0, 32), $urandom_range(0, 32));
    repeat (50) begin
      case ($urandom_range(0, 9))
        0: send_request(ACT_UNUSED, $urandom, $urandom, $urandom, $urandom);
        1, 2: send_request(ACT_LOAD, $urandom, $urandom, $urandom, $urandom);
        3: send_start();
        4: send_event(random_unknown_code());
        5: send_event(ST_START);
        6: send_event(ST_SLAW_ACK);
        7: send_event(ST_TXDATA_ACK);
        8: send_event(ST_RXDATA_ACK);
        default: begin
          case ($urandom_range(0, 6))
            0: send_event(ST_RESTART);
            1: send_event(ST_SLAW_NACK);
            2: send_event(ST_TXDATA_NACK);
            3: send_event(ST_ARB_LOST);
            4: send_event(ST_SLAR_ACK);
            5: send_event(ST_SLAR_NACK);
            default: send_event(ST_RXDATA_NACK);
          endcase
        end
      endcase
    end
  endtask

  // Result side: after each taken answer, hold ready low for a random number
  // of cycles drawn from the same range as the request side.
  always @(posedge clk) begin
    if (out_valid && out_ready) sink_wait = $urandom_range(0, gap_max);
    else if (sink_wait > 0) sink_wait = sink_wait - 1;
    out_ready <= (sink_wait == 0);
  end

  // Compares each taken answer with the oldest prediction, field by field.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      seen_answer.tx_valid = out_tx_valid;
      seen_answer.tx_byte = out_tx_byte;
      seen_answer.set_start = out_set_start;
      seen_answer.clear_start = out_clear_start;
      seen_answer.set_stop = out_set_stop;
      seen_answer.ack_control = out_ack_control;
      seen_answer.rx_valid = out_rx_valid;
      seen_answer.rx_index = out_rx_index;
      seen_answer.rx_byte = out_rx_byte;
      seen_answer.overflow = out_overflow;
      seen_answer.done_res = out_done_res;
      seen_answer.final_status = out_final_status;
      if (pending_answers.size() == 0) begin
        report_mismatch("answer with no request pending", seen_answer, 0);
      end else begin
        want_answer = pending_answers.pop_front();
        if (seen_answer.tx_valid !== want_answer.tx_valid)
          report_mismatch("tx_valid", seen_answer.tx_valid, want_answer.tx_valid);
        if (seen_answer.tx_byte !== want_answer.tx_byte)
          report_mismatch("tx_byte", seen_answer.tx_byte, want_answer.tx_byte);
        if (seen_answer.set_start !== want_answer.set_start)
          report_mismatch("set_start", seen_answer.set_start, want_answer.set_start);
        if (seen_answer.clear_start !== want_answer.clear_start)
          report_mismatch("clear_start", seen_answer.clear_start, want_answer.clear_start);
        if (seen_answer.set_stop !== want_answer.set_stop)
          report_mismatch("set_stop", seen_answer.set_stop, want_answer.set_stop);
        if (seen_answer.ack_control !== want_answer.ack_control)
          report_mismatch("ack_control", seen_answer.ack_control, want_answer.ack_control);
        if (seen_answer.rx_valid !== want_answer.rx_valid)
          report_mismatch("rx_valid", seen_answer.rx_valid, want_answer.rx_valid);
        if (seen_answer.rx_index !== want_answer.rx_index)
          report_mismatch("rx_index", seen_answer.rx_index, want_answer.rx_index);
        if (seen_answer.rx_byte !== want_answer.rx_byte)
          report_mismatch("rx_byte", seen_answer.rx_byte, want_answer.rx_byte);
        if (seen_answer.overflow !== want_answer.overflow)
          report_mismatch("overflow", seen_answer.overflow, want_answer.overflow);
        if (seen_answer.done_res !== want_answer.done_res)
          report_mismatch("done_res", seen_answer.done_res, want_answer.done_res);
        if (seen_answer.final_status !== want_answer.final_status)
          report_mismatch("final_status", seen_answer.final_status, want_answer.final_status);
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Reset once, fill the store, run the directed cases, then random transfers
  // until 220 loads and events have gone in, then overflow, saturation, noise.
  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    load_tx_store();
    test_directed();
    while (bus_requests < 220) begin
      test_write_only();
      test_read_only();
      test_write_restart_read();
      test_bus_faults();
    end
    test_receive_overflow();
    test_index_saturation();
    test_noise();
    wait_idle();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

/* files.f */
+incdir+design
design/i2cseq_pkg.sv
design/i2cseq_ctrl.sv
design/i2c_master_transaction_sequencer.sv
design/i2cseq_chk.sv
verif/testbench.sv
